/* rtl/core/tkh_pkg.sv */
// Shared types and constants for the top-k min-heap selector.
package tkh_pkg;

  localparam int MAX_ENTRIES_DEF = 64;

  localparam int KIND_W    = 2;
  localparam int SCORE_W   = 8;
  localparam int TAG_W     = 16;
  localparam int FILL_W    = 7;
  localparam int CAP_W     = 7;
  localparam int ENTRY_W   = SCORE_W + TAG_W;
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd50;

  // input tdata: offer_score, offer_tag
  localparam int S_DATA_W = 24;
  // output tdata: accepted, entry_score, entry_tag, entry_valid, fill_count, min_score
  localparam int M_FIELDS_W = 1 + SCORE_W + TAG_W + 1 + FILL_W + SCORE_W;
  localparam int M_DATA_W   = ((M_FIELDS_W + 7) / 8) * 8;

  typedef enum logic [KIND_W-1:0] {
    KIND_CLEAR = 2'd0,
    KIND_OFFER = 2'd1,
    KIND_DUMP  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UP,
    ST_UP_CMP,
    ST_DN_RDL,
    ST_DN_RDR,
    ST_DN_CMP,
    ST_RESP,
    ST_DUMP_RD,
    ST_DUMP_OUT
  } state_t;

endpackage

/* rtl/core/top_k_min_heap_selector_top.sv */
// Top-k min-heap selector: heap in one synchronous RAM, sift sequencer, APB capacity register.
//
//  channel | signals                                  | beat
//  s       | s_tvalid s_tready s_tdata s_tuser        | one command (clear, offer, dump)
//  m       | m_tvalid m_tready m_tdata m_tlast        | one result, tlast on the last of a command
//  apb     | psel penable pwrite paddr pwdata prdata  | capacity register at address 0
//
// Every heap level costs a RAM read plus a write: sift-up reads the parent, then
// compares and writes; sift-down reads the left child, reads the right child, then
// compares and writes. Clear, refused offers and the unused kind go straight to the
// response. A dump reads and sends each held entry in turn. New commands are taken only in idle.
// Reset (rst, synchronous) empties the heap and sets capacity to 50.
// A stalled m_tready holds the result register and the sequencer waits on it.
module top_k_min_heap_selector_top #(
  parameter int MAX_ENTRIES = tkh_pkg::MAX_ENTRIES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [tkh_pkg::S_DATA_W-1:0]  s_tdata,   // offer_score[7:0], offer_tag[23:8]
  input  logic [tkh_pkg::KIND_W-1:0]    s_tuser,   // kind[1:0]
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [tkh_pkg::M_DATA_W-1:0]  m_tdata,   // accepted[0], entry_score[8:1],
                                                   // entry_tag[24:9], entry_valid[25],
                                                   // fill_count[32:26], min_score[40:33]
  output logic                          m_tlast,   // is_last
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam int IDX_W = $clog2(MAX_ENTRIES);
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int CW    = IDX_W + 2;
  localparam int SW    = tkh_pkg::SCORE_W;
  localparam int TW    = tkh_pkg::TAG_W;
  localparam int EW    = tkh_pkg::ENTRY_W;
  localparam int FILL_W_L = tkh_pkg::FILL_W;

  tkh_pkg::state_t state, state_next;

  logic [tkh_pkg::CAP_W-1:0] cap_reg;
  logic [tkh_pkg::CAP_W-1:0] cap_eff;
  logic [CNT_W-1:0]          held, held_next;
  logic [SW-1:0]             root_score;

  logic [EW-1:0]             heap_mem [MAX_ENTRIES];
  logic [EW-1:0]             rdata;
  logic                      rd_en;
  logic [IDX_W-1:0]          rd_addr;
  logic                      wr_en;
  logic [IDX_W-1:0]          wr_addr;
  logic [EW-1:0]             wr_data;

  logic [SW-1:0]             mv_score, mv_score_next;
  logic [TW-1:0]             mv_tag, mv_tag_next;
  logic [IDX_W-1:0]          pos, pos_next;
  logic [EW-1:0]             lbuf;
  logic                      acc, acc_next;
  logic [IDX_W-1:0]          didx, didx_next;

  logic                      out_load;
  logic [tkh_pkg::M_DATA_W-1:0] out_data;
  logic                      out_last;

  // input fields
  tkh_pkg::kind_t            in_kind;
  logic [SW-1:0]             in_score;
  logic [TW-1:0]             in_tag;
  logic                      in_fire;

  // heap navigation
  logic [CW-1:0]             l_c, r_c, held_c;
  logic                      l_ok, r_ok;
  logic [IDX_W-1:0]          parent;
  logic [SW-1:0]             rd_score, lb_score;
  logic                      pick_r;
  logic [EW-1:0]             pick;
  logic [IDX_W-1:0]          pick_idx;
  logic                      out_free;
  logic                      dump_last;
  logic [FILL_W_L-1:0]       fill7;
  logic [SW-1:0]             min_now;

  assign in_kind  = tkh_pkg::kind_t'(s_tuser);
  assign in_score = s_tdata[SW-1:0];
  assign in_tag   = s_tdata[SW+TW-1:SW];
  assign s_tready = (state == tkh_pkg::ST_IDLE);
  assign in_fire  = s_tvalid && s_tready;

  assign cap_eff = (cap_reg == '0) ? tkh_pkg::CAP_W'(1) :
                   (cap_reg > tkh_pkg::CAP_W'(MAX_ENTRIES)) ? tkh_pkg::CAP_W'(MAX_ENTRIES) :
                   cap_reg;

  assign l_c      = {1'b0, pos, 1'b1};
  assign r_c      = l_c + CW'(1);
  assign held_c   = CW'(held);
  assign l_ok     = l_c < held_c;
  assign r_ok     = r_c < held_c;
  assign parent   = (pos - IDX_W'(1)) >> 1;
  assign rd_score = rdata[SW-1:0];
  assign lb_score = lbuf[SW-1:0];
  // equal children: left wins
  assign pick_r   = r_ok && (rd_score < lb_score);
  assign pick     = pick_r ? rdata : lbuf;
  assign pick_idx = pick_r ? r_c[IDX_W-1:0] : l_c[IDX_W-1:0];

  assign out_free  = !m_tvalid || m_tready;
  assign dump_last = (CNT_W'(didx) + CNT_W'(1)) == held;
  assign fill7     = FILL_W_L'(held);
  assign min_now   = (held != '0) ? root_score : '0;

  // APB
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? 32'(cap_reg) : 32'd0;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      tkh_pkg::ST_IDLE: begin
        if (in_fire) begin
          case (in_kind)
            tkh_pkg::KIND_OFFER: begin
              if (tkh_pkg::CAP_W'(held) < cap_eff) begin
                state_next = tkh_pkg::ST_UP;
              end else if (held != '0 && in_score > root_score) begin
                state_next = tkh_pkg::ST_DN_RDL;
              end else begin
                state_next = tkh_pkg::ST_RESP;
              end
            end
            tkh_pkg::KIND_DUMP: begin
              state_next = (held == '0) ? tkh_pkg::ST_RESP : tkh_pkg::ST_DUMP_RD;
            end
            default: state_next = tkh_pkg::ST_RESP;
          endcase
        end
      end
      tkh_pkg::ST_UP:     state_next = (pos == '0) ? tkh_pkg::ST_RESP : tkh_pkg::ST_UP_CMP;
      tkh_pkg::ST_UP_CMP: state_next = (mv_score < rd_score) ? tkh_pkg::ST_UP : tkh_pkg::ST_RESP;
      tkh_pkg::ST_DN_RDL: state_next = l_ok ? tkh_pkg::ST_DN_RDR : tkh_pkg::ST_RESP;
      tkh_pkg::ST_DN_RDR: state_next = tkh_pkg::ST_DN_CMP;
      tkh_pkg::ST_DN_CMP: begin
        state_next = (pick[SW-1:0] < mv_score) ? tkh_pkg::ST_DN_RDL : tkh_pkg::ST_RESP;
      end
      tkh_pkg::ST_RESP:     state_next = out_free ? tkh_pkg::ST_IDLE : tkh_pkg::ST_RESP;
      tkh_pkg::ST_DUMP_RD:  state_next = tkh_pkg::ST_DUMP_OUT;
      tkh_pkg::ST_DUMP_OUT: begin
        if (out_free) begin
          state_next = dump_last ? tkh_pkg::ST_IDLE : tkh_pkg::ST_DUMP_RD;
        end
      end
      default: state_next = tkh_pkg::ST_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    rd_en         = 1'b0;
    rd_addr       = '0;
    wr_en         = 1'b0;
    wr_addr       = pos;
    wr_data       = {mv_tag, mv_score};
    held_next     = held;
    mv_score_next = mv_score;
    mv_tag_next   = mv_tag;
    pos_next      = pos;
    acc_next      = acc;
    didx_next     = didx;
    out_load      = 1'b0;
    out_data      = '0;
    out_last      = 1'b1;
    case (state)
      tkh_pkg::ST_IDLE: begin
        if (in_fire) begin
          acc_next      = 1'b0;
          didx_next     = '0;
          mv_score_next = in_score;
          mv_tag_next   = in_tag;
          case (in_kind)
            tkh_pkg::KIND_CLEAR: held_next = '0;
            tkh_pkg::KIND_OFFER: begin
              if (tkh_pkg::CAP_W'(held) < cap_eff) begin
                // hole at the new leaf
                pos_next  = held[IDX_W-1:0];
                held_next = held + CNT_W'(1);
                acc_next  = 1'b1;
              end else if (held != '0 && in_score > root_score) begin
                // hole at the root
                pos_next = '0;
                acc_next = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      tkh_pkg::ST_UP: begin
        if (pos == '0) begin
          wr_en = 1'b1;
        end else begin
          rd_en   = 1'b1;
          rd_addr = parent;
        end
      end
      tkh_pkg::ST_UP_CMP: begin
        wr_en = 1'b1;
        if (mv_score < rd_score) begin
          wr_data  = rdata;
          pos_next = parent;
        end
      end
      tkh_pkg::ST_DN_RDL: begin
        if (l_ok) begin
          rd_en   = 1'b1;
          rd_addr = l_c[IDX_W-1:0];
        end else begin
          wr_en = 1'b1;
        end
      end
      tkh_pkg::ST_DN_RDR: begin
        if (r_ok) begin
          rd_en   = 1'b1;
          rd_addr = r_c[IDX_W-1:0];
        end
      end
      tkh_pkg::ST_DN_CMP: begin
        wr_en = 1'b1;
        if (pick[SW-1:0] < mv_score) begin
          wr_data  = pick;
          pos_next = pick_idx;
        end
      end
      tkh_pkg::ST_RESP: begin
        out_load = out_free;
        out_data = tkh_pkg::M_DATA_W'({min_now, fill7, 1'b0, {TW{1'b0}}, {SW{1'b0}}, acc});
      end
      tkh_pkg::ST_DUMP_RD: begin
        rd_en   = 1'b1;
        rd_addr = didx;
      end
      tkh_pkg::ST_DUMP_OUT: begin
        out_load = out_free;
        out_last = dump_last;
        out_data = tkh_pkg::M_DATA_W'({min_now, fill7, 1'b1, rdata[EW-1:SW], rd_score, 1'b0});
        if (out_free) begin
          didx_next = didx + IDX_W'(1);
        end
      end
      default: ;
    endcase
  end

  // heap RAM
  always_ff @(posedge clk) begin
    if (wr_en) begin
      heap_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= heap_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= tkh_pkg::ST_IDLE;
      held     <= '0;
      cap_reg  <= tkh_pkg::CAP_RESET;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      held  <= held_next;
      if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
        cap_reg <= pwdata[tkh_pkg::CAP_W-1:0];
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    mv_score <= mv_score_next;
    mv_tag   <= mv_tag_next;
    pos      <= pos_next;
    acc      <= acc_next;
    didx     <= didx_next;
    if (state == tkh_pkg::ST_DN_RDR) begin
      lbuf <= rdata;
    end
    // shadow of the root score for the refuse test and min_score
    if (wr_en && wr_addr == '0) begin
      root_score <= wr_data[SW-1:0];
    end
    if (out_load) begin
      m_tdata <= out_data;
      m_tlast <= out_last;
    end
  end

endmodule

/* bench/top_k_min_heap_selector_top_tb.sv */
// Self-checking bench for the top-k min-heap selector: directed cases, then random streams.
module top_k_min_heap_selector_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HEAP_DEPTH = tkh_pkg::MAX_ENTRIES_DEF;
  localparam logic [2:0] REG_CAPACITY = 3'd0;
  localparam int MAX_REPORTS = 200;

  typedef struct packed {
    logic                        accepted;
    logic [tkh_pkg::SCORE_W-1:0] score;
    logic [tkh_pkg::TAG_W-1:0]   tag;
    logic                        valid;
    logic [tkh_pkg::FILL_W-1:0]  fill;
    logic [tkh_pkg::SCORE_W-1:0] min_score;
    logic                        last;
  } heap_rsp_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         s_tvalid = 1'b0;
  logic                         s_tready;
  logic [tkh_pkg::S_DATA_W-1:0] s_tdata = '0;   // offer_score[7:0], offer_tag[23:8]
  logic [tkh_pkg::KIND_W-1:0]   s_tuser = '0;   // kind[1:0]
  logic                         m_tvalid;
  logic                         m_tready = 1'b0;
  logic [tkh_pkg::M_DATA_W-1:0] m_tdata;        // accepted, entry_score, entry_tag,
                                                // entry_valid, fill_count, min_score
  logic                         m_tlast;        // is_last
  logic                         psel = 1'b0;
  logic                         penable = 1'b0;
  logic                         pwrite = 1'b0;
  logic [2:0]                   paddr = '0;
  logic [31:0]                  pwdata = '0;
  logic [31:0]                  prdata;
  logic                         pready;

  top_k_min_heap_selector_top dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // shadow heap
  logic [tkh_pkg::SCORE_W-1:0] shadow_scores [HEAP_DEPTH];
  logic [tkh_pkg::TAG_W-1:0]   shadow_tags   [HEAP_DEPTH];
  int                          shadow_fill = 0;
  logic [tkh_pkg::CAP_W-1:0]   shadow_cap = tkh_pkg::CAP_RESET;

  heap_rsp_t pending_rsp[$];
  int        n_errors = 0;
  bit        idling_on = 1'b1;

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("top_k_min_heap_selector_top test failed");
    $finish;
  end

  // receiver stalls
  always @(negedge clk) begin
    m_tready <= idling_on ? ($urandom_range(0, 99) >= 19) : 1'b1;
  end

  function automatic void swap_slots(int a, int b);
    logic [tkh_pkg::SCORE_W-1:0] s;
    logic [tkh_pkg::TAG_W-1:0]   t;
    s = shadow_scores[a];
    t = shadow_tags[a];
    shadow_scores[a] = shadow_scores[b];
    shadow_tags[a] = shadow_tags[b];
    shadow_scores[b] = s;
    shadow_tags[b] = t;
  endfunction

  function automatic void push_rsp(logic acc, logic [tkh_pkg::SCORE_W-1:0] sc,
                                   logic [tkh_pkg::TAG_W-1:0] tg, logic vld, logic last);
    heap_rsp_t r;
    r.accepted  = acc;
    r.score     = sc;
    r.tag       = tg;
    r.valid     = vld;
    r.fill      = tkh_pkg::FILL_W'(shadow_fill);
    r.min_score = (shadow_fill > 0) ? shadow_scores[0] : '0;
    r.last      = last;
    pending_rsp.push_back(r);
  endfunction

  function automatic void update_heap(tkh_pkg::kind_t k, logic [tkh_pkg::SCORE_W-1:0] sc,
                                      logic [tkh_pkg::TAG_W-1:0] tg);
    int  lim;
    int  p;
    int  up;
    int  l;
    int  pick;
    logic acc;
    lim = shadow_cap;
    if (lim < 1) lim = 1;
    if (lim > HEAP_DEPTH) lim = HEAP_DEPTH;
    acc = 1'b0;
    case (k)
      tkh_pkg::KIND_CLEAR: begin
        shadow_fill = 0;
      end
      tkh_pkg::KIND_OFFER: begin
        if (shadow_fill < lim) begin
          shadow_scores[shadow_fill] = sc;
          shadow_tags[shadow_fill] = tg;
          p = shadow_fill;
          shadow_fill++;
          while (p > 0) begin
            up = (p - 1) / 2;
            if (shadow_scores[p] >= shadow_scores[up]) break;
            swap_slots(p, up);
            p = up;
          end
          acc = 1'b1;
        end else if (shadow_fill > 0 && sc > shadow_scores[0]) begin
          shadow_scores[0] = sc;
          shadow_tags[0] = tg;
          p = 0;
          forever begin
            l = 2 * p + 1;
            if (l >= shadow_fill) break;
            pick = l;
            // ties between children go left
            if (l + 1 < shadow_fill && shadow_scores[l + 1] < shadow_scores[l]) pick = l + 1;
            if (shadow_scores[pick] >= shadow_scores[p]) break;
            swap_slots(p, pick);
            p = pick;
          end
          acc = 1'b1;
        end
      end
      tkh_pkg::KIND_DUMP: begin
        if (shadow_fill == 0) begin
          push_rsp(1'b0, '0, '0, 1'b0, 1'b1);
        end else begin
          for (int i = 0; i < shadow_fill; i++)
            push_rsp(1'b0, shadow_scores[i], shadow_tags[i], 1'b1, i == shadow_fill - 1);
        end
        return;
      end
      default: ;
    endcase
    push_rsp(acc, '0, '0, 1'b0, 1'b1);
  endfunction

  always @(posedge clk) begin : result_check
    heap_rsp_t got;
    heap_rsp_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.accepted  = m_tdata[0];
      got.score     = m_tdata[8:1];
      got.tag       = m_tdata[24:9];
      got.valid     = m_tdata[25];
      got.fill      = m_tdata[32:26];
      got.min_score = m_tdata[40:33];
      got.last      = m_tlast;
      if (pending_rsp.size() == 0) begin
        n_errors++;
        if (n_errors <= MAX_REPORTS)
          $display({"%0t: unexpected result beat acc=%0d score=%0d tag=%h vld=%0d",
                    " fill=%0d min=%0d last=%0d"},
                   $time, got.accepted, got.score, got.tag, got.valid, got.fill,
                   got.min_score, got.last);
      end else begin
        want = pending_rsp.pop_front();
        if (got !== want) begin
          n_errors++;
          if (n_errors <= MAX_REPORTS)
            $display({"%0t: mismatch exp acc=%0d score=%0d tag=%h vld=%0d fill=%0d",
                      " min=%0d last=%0d | got acc=%0d score=%0d tag=%h vld=%0d",
                      " fill=%0d min=%0d last=%0d"},
                     $time, want.accepted, want.score, want.tag, want.valid, want.fill,
                     want.min_score, want.last, got.accepted, got.score, got.tag,
                     got.valid, got.fill, got.min_score, got.last);
        end
      end
    end
  end

  task automatic send_cmd(tkh_pkg::kind_t k, logic [tkh_pkg::SCORE_W-1:0] sc,
                          logic [tkh_pkg::TAG_W-1:0] tg);
    int gap;
    @(negedge clk);
    if (idling_on && $urandom_range(0, 99) < 19) begin
      gap = $urandom_range(1, 4);
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= k;
    s_tdata  <= {tg, sc};
    do @(posedge clk); while (!s_tready);
    update_heap(k, sc, tg);
  endtask

  // hold the sender off until every expected beat has arrived
  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
  endtask

  // write the capacity register, then read it back; only called with the block idle
  task automatic set_capacity(logic [tkh_pkg::CAP_W-1:0] val);
    drain();
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= REG_CAPACITY; pwdata <= 32'(val);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    shadow_cap = val;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(negedge clk);
    psel <= 1'b1;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[tkh_pkg::CAP_W-1:0] !== val) begin
      n_errors++;
      $display("%0t: capacity readback exp=%0d got=%0d", $time, val,
               prdata[tkh_pkg::CAP_W-1:0]);
    end
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0;
  endtask

  task automatic test_empty_heap();
    send_cmd(tkh_pkg::KIND_DUMP, 8'h00, 16'h0000);
    send_cmd(tkh_pkg::KIND_NONE, 8'hff, 16'hffff);
    send_cmd(tkh_pkg::KIND_CLEAR, 8'h5a, 16'ha5a5);
  endtask

  task automatic test_offer_extremes();
    send_cmd(tkh_pkg::KIND_OFFER, 8'hff, 16'hffff);
    send_cmd(tkh_pkg::KIND_OFFER, 8'h00, 16'h0000);
    send_cmd(tkh_pkg::KIND_OFFER, 8'h00, 16'h1234);   // equal to root, heap not full
    send_cmd(tkh_pkg::KIND_OFFER, 8'h80, 16'haaaa);
    send_cmd(tkh_pkg::KIND_OFFER, 8'h80, 16'h5555);
    send_cmd(tkh_pkg::KIND_DUMP, 8'h00, 16'h0000);
    send_cmd(tkh_pkg::KIND_CLEAR, 8'h00, 16'h0000);
  endtask

  // capacity 0 behaves as a single slot
  task automatic test_single_slot();
    set_capacity(7'd0);
    send_cmd(tkh_pkg::KIND_OFFER, 8'd10, 16'h0001);
    send_cmd(tkh_pkg::KIND_OFFER, 8'd10, 16'h0002);   // tie with root of full heap: refused
    send_cmd(tkh_pkg::KIND_OFFER, 8'd11, 16'h0003);
    send_cmd(tkh_pkg::KIND_OFFER, 8'd5, 16'h0004);
    send_cmd(tkh_pkg::KIND_DUMP, 8'h00, 16'h0000);
  endtask

  // capacity above depth, then lowered below the fill
  task automatic test_capacity_shrink();
    set_capacity(7'd127);
    send_cmd(tkh_pkg::KIND_OFFER, 8'd40, 16'h0040);
    send_cmd(tkh_pkg::KIND_OFFER, 8'd20, 16'h0020);
    send_cmd(tkh_pkg::KIND_OFFER, 8'd30, 16'h0030);
    send_cmd(tkh_pkg::KIND_OFFER, 8'd20, 16'h0021);
    send_cmd(tkh_pkg::KIND_OFFER, 8'd15, 16'h0015);
    set_capacity(7'd2);
    send_cmd(tkh_pkg::KIND_OFFER, 8'd3, 16'h0003);
    send_cmd(tkh_pkg::KIND_OFFER, 8'd200, 16'h00c8);
    send_cmd(tkh_pkg::KIND_DUMP, 8'h00, 16'h0000);
  endtask

  task automatic run_stream(logic [tkh_pkg::CAP_W-1:0] lim, int n_items, int clear_pct,
                            bit narrow);
    int r;
    logic [tkh_pkg::SCORE_W-1:0] sc;
    logic [tkh_pkg::TAG_W-1:0]   tg;
    tkh_pkg::kind_t k;
    set_capacity(lim);
    for (int i = 0; i < n_items; i++) begin
      r  = $urandom_range(0, 99);
      tg = tkh_pkg::TAG_W'($urandom_range(0, 65535));
      if (narrow && $urandom_range(0, 1)) sc = tkh_pkg::SCORE_W'($urandom_range(120, 127));
      else sc = tkh_pkg::SCORE_W'($urandom_range(0, 255));
      if (r < clear_pct) k = tkh_pkg::KIND_CLEAR;
      else if (r < clear_pct + 8) k = tkh_pkg::KIND_DUMP;
      else if (r < clear_pct + 11) k = tkh_pkg::KIND_NONE;
      else k = tkh_pkg::KIND_OFFER;
      send_cmd(k, sc, tg);
      if ($urandom_range(0, 99) == 0) drain();
    end
  endtask

  task automatic test_random_small_capacity();
    run_stream(7'd7, 60, 3, 1'b1);
    run_stream(7'd1, 40, 2, 1'b1);
    run_stream(7'd2, 40, 2, 1'b0);
  endtask

  task automatic test_random_full_depth();
    idling_on = 1'b0;
    run_stream(7'd64, 110, 0, 1'b1);
    idling_on = 1'b1;
    run_stream(7'd100, 40, 2, 1'b0);
  endtask

  task automatic test_random_default();
    run_stream(tkh_pkg::CAP_RESET, 60, 4, 1'b0);
    run_stream(tkh_pkg::CAP_W'($urandom_range(0, 127)), 36, 3, 1'b1);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_empty_heap();
    test_offer_extremes();
    test_single_slot();
    test_capacity_shrink();
    test_random_small_capacity();
    test_random_full_depth();
    test_random_default();
    drain();
    repeat (40) @(posedge clk);
    if (n_errors == 0 && pending_rsp.size() == 0) begin
      $display("top_k_min_heap_selector_top test passed");
    end else begin
      if (pending_rsp.size() != 0)
        $display("%0t: %0d expected beats never arrived", $time, pending_rsp.size());
      $display("top_k_min_heap_selector_top test failed");
    end
    $finish;
  end

endmodule

/* top_k_min_heap_selector_top.f */
rtl/core/tkh_pkg.sv
rtl/core/top_k_min_heap_selector_top.sv
bench/top_k_min_heap_selector_top_tb.sv
